[hdl/bbc_pkg.sv]
// ----------------------------------------------------------------------------
// bbc_pkg
// Shared types, codes and helpers for the bracket balance checker.
// ----------------------------------------------------------------------------
`default_nettype none

package bbc_pkg;

    localparam int BBC_STACK_DEPTH = 128;

    localparam logic [7:0] CH_OPEN_ROUND   = 8'h28;  // (
    localparam logic [7:0] CH_CLOSE_ROUND  = 8'h29;  // )
    localparam logic [7:0] CH_OPEN_SQUARE  = 8'h5B;  // [
    localparam logic [7:0] CH_CLOSE_SQUARE = 8'h5D;  // ]
    localparam logic [7:0] CH_OPEN_CURLY   = 8'h7B;  // {
    localparam logic [7:0] CH_CLOSE_CURLY  = 8'h7D;  // }

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_MISMATCH = 3'd1;
    localparam logic [2:0] ST_EMPTY    = 3'd2;
    localparam logic [2:0] ST_UNCLOSED = 3'd3;
    localparam logic [2:0] ST_OVERFLOW = 3'd4;

    typedef enum logic [1:0] {
        KIND_ROUND  = 2'd0,
        KIND_SQUARE = 2'd1,
        KIND_CURLY  = 2'd2,
        KIND_NONE   = 2'd3
    } t_kind;

    typedef struct packed {
        logic       balanced;
        logic [2:0] status;
    } t_result;

    function automatic t_kind opener_kind(input logic [7:0] ch);
        t_kind k;
        case (ch)
            CH_OPEN_ROUND:  k = KIND_ROUND;
            CH_OPEN_SQUARE: k = KIND_SQUARE;
            CH_OPEN_CURLY:  k = KIND_CURLY;
            default:        k = KIND_NONE;
        endcase
        return k;
    endfunction

    function automatic t_kind closer_kind(input logic [7:0] ch);
        t_kind k;
        case (ch)
            CH_CLOSE_ROUND:  k = KIND_ROUND;
            CH_CLOSE_SQUARE: k = KIND_SQUARE;
            CH_CLOSE_CURLY:  k = KIND_CURLY;
            default:         k = KIND_NONE;
        endcase
        return k;
    endfunction

endpackage

`default_nettype wire

[hdl/bbc_if.sv]
// ----------------------------------------------------------------------------
// bbc_if
// Valid/ready channels for the character stream and the result stream.
// ----------------------------------------------------------------------------
`default_nettype none

interface bbc_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] ch;
    logic       last;

    modport source (output valid, output ch, output last, input ready);
    modport sink   (input valid, input ch, input last, output ready);
endinterface

interface bbc_out_if;
    logic       valid;
    logic       ready;
    logic       balanced;
    logic [2:0] status;

    modport source (output valid, output balanced, output status, input ready);
    modport sink   (input valid, input balanced, input status, output ready);
endinterface

`default_nettype wire

[hdl/bbc_stack_mem.sv]
// ----------------------------------------------------------------------------
// bbc_stack_mem
// Kind stack storage: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
`default_nettype none

module bbc_stack_mem #(
    parameter int DEPTH = bbc_pkg::BBC_STACK_DEPTH,
    parameter int AW    = $clog2(DEPTH)
) (
    input  wire logic            i_clk,
    input  wire logic            i_we,
    input  wire logic [AW-1:0]   i_waddr,
    input  wire bbc_pkg::t_kind  i_wdata,
    input  wire logic [AW-1:0]   i_raddr,
    output bbc_pkg::t_kind       o_rdata
);
    import bbc_pkg::*;

    t_kind r_mem [DEPTH];
    t_kind r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

[hdl/bbc_out_reg.sv]
// ----------------------------------------------------------------------------
// bbc_out_reg
// Result output register; frees itself when the word is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module bbc_out_reg (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_load,
    input  wire bbc_pkg::t_result i_result,
    output logic                  o_free,
    bbc_out_if.source             o_out
);
    import bbc_pkg::*;

    logic    r_valid;
    t_result r_result;

    // free when empty or when the held word leaves this cycle
    assign o_free = !r_valid || o_out.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_free) begin
            r_valid <= i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

    assign o_out.valid    = r_valid;
    assign o_out.balanced = r_result.balanced;
    assign o_out.status   = r_result.status;

endmodule

`default_nettype wire

[hdl/bracket_balance_checker.sv]
// o_out.valid rises in the cycle after the last character of a string is accepted.
// Throughput: one character per cycle; the stack top is held in a register and
// the memory read port prefetches the entry below it, so back-to-back pops work.
// Input stalls only while a result word waits and o_out.ready is low.
// Reset clears stack count, failure code and output valid; the stack memory
// itself is not cleared (entries are always written before they are read).
// ----------------------------------------------------------------------------
// bracket_balance_checker
// Checks bracket nesting of a character stream, one result per string.
// ----------------------------------------------------------------------------
`default_nettype none

module bracket_balance_checker #(
    parameter int STACK_DEPTH = bbc_pkg::BBC_STACK_DEPTH
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    bbc_in_if.sink     i_in,
    bbc_out_if.source  o_out
);
    import bbc_pkg::*;

    localparam int AW = $clog2(STACK_DEPTH);
    localparam int CW = $clog2(STACK_DEPTH + 1);

    logic [CW-1:0] r_count, n_count;
    logic [2:0]    r_fail, n_fail;
    t_kind         r_top, n_top;

    logic          out_free;
    logic          acc;
    logic          load;
    t_result       result;
    t_kind         ok_kind, cl_kind;
    t_kind         below;
    logic          we;
    logic [CW-1:0] below_idx;
    logic [AW-1:0] raddr;
    logic [2:0]    fail_step;
    logic [CW-1:0] count_step;

    assign i_in.ready = out_free;
    assign acc        = i_in.valid && out_free;
    assign ok_kind    = opener_kind(i_in.ch);
    assign cl_kind    = closer_kind(i_in.ch);

    always_comb begin
        we         = 1'b0;
        n_top      = r_top;
        fail_step  = r_fail;
        count_step = r_count;
        if (acc && r_fail == ST_OK) begin
            if (ok_kind != KIND_NONE) begin
                if (r_count == CW'(STACK_DEPTH)) begin
                    fail_step = ST_OVERFLOW;
                end else begin
                    we         = 1'b1;
                    n_top      = ok_kind;
                    count_step = r_count + CW'(1);
                end
            end else if (cl_kind != KIND_NONE) begin
                if (r_count == '0) begin
                    fail_step = ST_EMPTY;
                end else begin
                    count_step = r_count - CW'(1);
                    n_top      = below;
                    if (r_top != cl_kind) begin
                        fail_step = ST_MISMATCH;
                    end
                end
            end
        end

        load = acc && i_in.last;
        if (fail_step != ST_OK) begin
            result.status = fail_step;
        end else if (count_step != '0) begin
            result.status = ST_UNCLOSED;
        end else begin
            result.status = ST_OK;
        end
        result.balanced = (result.status == ST_OK);

        if (load) begin
            n_count = '0;
            n_fail  = ST_OK;
        end else begin
            n_count = count_step;
            n_fail  = fail_step;
        end
    end

    // prefetch the entry just below the new top for the next cycle
    assign below_idx = n_count - CW'(2);
    assign raddr     = below_idx[AW-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_fail  <= ST_OK;
        end else begin
            r_count <= n_count;
            r_fail  <= n_fail;
        end
    end

    always_ff @(posedge i_clk) begin
        r_top <= n_top;
    end

    bbc_stack_mem #(
        .DEPTH (STACK_DEPTH),
        .AW    (AW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (r_count[AW-1:0]),
        .i_wdata (ok_kind),
        .i_raddr (raddr),
        .o_rdata (below)
    );

    bbc_out_reg u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (load),
        .i_result (result),
        .o_free   (out_free),
        .o_out    (o_out)
    );

endmodule

`default_nettype wire

[hdl/bbc_checker.sv]
// ----------------------------------------------------------------------------
// bbc_checker
// Port-level checks for the bracket balance checker, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module bbc_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       i_in_valid,
    input wire logic       i_in_ready,
    input wire logic       i_in_last,
    input wire logic       i_out_valid,
    input wire logic       i_out_ready,
    input wire logic       i_out_balanced,
    input wire logic [2:0] i_out_status
);
    import bbc_pkg::*;

    // no result word right after reset
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result word valid after reset");

    a_balanced_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_out_balanced == (i_out_status == ST_OK)))
        else $error("balanced flag disagrees with status");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_out_status == ST_OK || i_out_status == ST_MISMATCH ||
                         i_out_status == ST_EMPTY || i_out_status == ST_UNCLOSED ||
                         i_out_status == ST_OVERFLOW))
        else $error("status code out of range");

    // a new word only follows an accepted last character
    a_word_from_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !$past(i_out_valid && !i_out_ready))
            |-> $past(i_in_valid && i_in_ready && i_in_last))
        else $error("result word without a last character");

    a_hold_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=>
            (i_out_valid && $stable(i_out_balanced) && $stable(i_out_status)))
        else $error("stalled result word changed");

endmodule

bind bracket_balance_checker bbc_checker u_bbc_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_in.valid),
    .i_in_ready     (i_in.ready),
    .i_in_last      (i_in.last),
    .i_out_valid    (o_out.valid),
    .i_out_ready    (o_out.ready),
    .i_out_balanced (o_out.balanced),
    .i_out_status   (o_out.status)
);

`default_nettype wire

[dv/bracket_balance_checker_tb.sv]
// ----------------------------------------------------------------------------
// bracket_balance_checker_tb
// Streams character words into the checker and compares each per-string
// verdict against a cycle-free nesting tracker kept inside the bench. Short
// hand-written strings come first, then two full-depth strings, then random
// nested strings (some broken) and random byte noise, under random idle and stall.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module bracket_balance_checker_tb;

    import bbc_pkg::*;

    typedef struct {
        logic [7:0] ch;
        logic       last;
        bit         drain;   // hold this word until every verdict is back
    } t_char_word;

    logic i_clk = 1'b0;
    logic i_rst_n;

    bbc_in_if  in_ch ();
    bbc_out_if out_ch ();

    bracket_balance_checker dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    t_char_word text_q[$];
    t_result    verdict_q[$];
    int         n_fail    = 0;
    int         n_live    = 0;
    bit         hold_next = 1'b0;
    int         cyc       = 0;
    logic       quiet;

    // Tracker state
    t_kind      nest_stack[BBC_STACK_DEPTH];
    int         nest_depth = 0;
    logic [2:0] fault      = ST_OK;

    always @(posedge i_clk) cyc <= cyc + 1;

    // no idling or stalls on either side inside this window
    assign quiet = (cyc >= 600) && (cyc < 1100);

    function automatic t_kind bracket_kind(input logic [7:0] ch);
        case (ch)
            CH_OPEN_ROUND,  CH_CLOSE_ROUND:  return KIND_ROUND;
            CH_OPEN_SQUARE, CH_CLOSE_SQUARE: return KIND_SQUARE;
            CH_OPEN_CURLY,  CH_CLOSE_CURLY:  return KIND_CURLY;
            default:                         return KIND_NONE;
        endcase
    endfunction

    function automatic logic [7:0] open_char(input t_kind k);
        case (k)
            KIND_ROUND:  return CH_OPEN_ROUND;
            KIND_SQUARE: return CH_OPEN_SQUARE;
            default:     return CH_OPEN_CURLY;
        endcase
    endfunction

    function automatic logic [7:0] close_char(input t_kind k);
        case (k)
            KIND_ROUND:  return CH_CLOSE_ROUND;
            KIND_SQUARE: return CH_CLOSE_SQUARE;
            default:     return CH_CLOSE_CURLY;
        endcase
    endfunction

    // Advance the nesting tracker by one accepted word.
    task automatic scan_char(input logic [7:0] ch, input logic last);
        t_result r;
        if (fault == ST_OK) begin
            case (ch)
                CH_OPEN_ROUND, CH_OPEN_SQUARE, CH_OPEN_CURLY: begin
                    if (nest_depth >= BBC_STACK_DEPTH) begin
                        fault = ST_OVERFLOW;
                    end else begin
                        nest_stack[nest_depth] = bracket_kind(ch);
                        nest_depth++;
                    end
                end
                CH_CLOSE_ROUND, CH_CLOSE_SQUARE, CH_CLOSE_CURLY: begin
                    if (nest_depth == 0) begin
                        fault = ST_EMPTY;
                    end else begin
                        nest_depth--;
                        if (nest_stack[nest_depth] != bracket_kind(ch))
                            fault = ST_MISMATCH;
                    end
                end
                default: ;
            endcase
        end
        if (last) begin
            if (fault != ST_OK)
                r.status = fault;
            else if (nest_depth != 0)
                r.status = ST_UNCLOSED;
            else
                r.status = ST_OK;
            r.balanced = (r.status == ST_OK);
            verdict_q.push_back(r);
            nest_depth = 0;
            fault      = ST_OK;
        end
    endtask

    task automatic push_char(input logic [7:0] ch, input logic last);
        t_char_word w;
        w.ch      = ch;
        w.last    = last;
        w.drain   = hold_next;
        hold_next = 1'b0;
        text_q.push_back(w);
        n_live++;
    endtask

    task automatic push_text(input string str);
        for (int i = 0; i < str.len(); i++)
            push_char(str[i], i == str.len() - 1);
    endtask

    task automatic push_seq(input logic [7:0] s[$]);
        for (int i = 0; i < s.size(); i++)
            push_char(s[i], i == s.size() - 1);
    endtask

    // Random well-nested string with some noise, optionally broken once.
    task automatic gen_nested(input int max_len, input bit corrupt);
        logic [7:0] s[$];
        t_kind      open_k[$];
        t_kind      k;
        int         n;
        int         r;
        int         pos;
        n = $urandom_range(1, max_len);
        for (int i = 0; i < n; i++) begin
            r = $urandom_range(0, 99);
            if (r < 10) begin
                s.push_back(8'($urandom_range(0, 255)));
            end else if (open_k.size() > 0 && r < 55) begin
                s.push_back(close_char(open_k.pop_back()));
            end else if (open_k.size() < BBC_STACK_DEPTH) begin
                k = t_kind'($urandom_range(0, 2));
                open_k.push_back(k);
                s.push_back(open_char(k));
            end
        end
        while (open_k.size() > 0)
            s.push_back(close_char(open_k.pop_back()));
        if (corrupt) begin
            pos = $urandom_range(0, s.size() - 1);
            r   = $urandom_range(0, 3);
            if (r == 0)
                s[pos] = close_char(t_kind'($urandom_range(0, 2)));
            else if (r == 1)
                s.delete(pos);
            else if (r == 2)
                s.insert(pos, close_char(t_kind'($urandom_range(0, 2))));
            else
                s.push_back(open_char(t_kind'($urandom_range(0, 2))));
        end
        if (s.size() == 0)
            s.push_back(8'h20);
        push_seq(s);
    endtask

    // Arbitrary bytes, at least half of them brackets of either direction.
    task automatic gen_noise(input int max_len);
        logic [7:0] s[$];
        t_kind      k;
        int         n;
        n = $urandom_range(1, max_len);
        for (int i = 0; i < n; i++) begin
            k = t_kind'($urandom_range(0, 2));
            case ($urandom_range(0, 3))
                0:       s.push_back(open_char(k));
                1:       s.push_back(close_char(k));
                default: s.push_back(8'($urandom_range(0, 255)));
            endcase
        end
        push_seq(s);
    endtask

    // n_open openers; then either close them all or end on one stray closer.
    task automatic gen_deep(input int n_open, input bit close_all);
        logic [7:0] s[$];
        t_kind      open_k[$];
        t_kind      k;
        for (int i = 0; i < n_open; i++) begin
            k = t_kind'($urandom_range(0, 2));
            open_k.push_back(k);
            s.push_back(open_char(k));
        end
        if (close_all) begin
            while (open_k.size() > 0)
                s.push_back(close_char(open_k.pop_back()));
        end else begin
            s.push_back(CH_CLOSE_ROUND);
        end
        push_seq(s);
    endtask

    // Driver: one word in flight, refilled from text_q.
    always @(posedge i_clk) begin : drive_proc
        t_char_word w;
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
        end else begin
            if (in_ch.valid && in_ch.ready)
                scan_char(in_ch.ch, in_ch.last);
            if (!in_ch.valid || in_ch.ready) begin
                if (text_q.size() > 0 && !(text_q[0].drain && verdict_q.size() != 0)
                        && (quiet || $urandom_range(0, 99) >= 10)) begin
                    w = text_q.pop_front();
                    in_ch.valid <= 1'b1;
                    in_ch.ch    <= w.ch;
                    in_ch.last  <= w.last;
                end else begin
                    in_ch.valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: compare each verdict word with the oldest prediction.
    always @(posedge i_clk) begin : check_proc
        t_result want;
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                if (verdict_q.size() == 0) begin
                    $display("%0t: unexpected verdict balanced=%0b status=%0d",
                             $time, out_ch.balanced, out_ch.status);
                    n_fail++;
                end else begin
                    want = verdict_q.pop_front();
                    if (out_ch.balanced !== want.balanced) begin
                        $display("%0t: balanced expected %0b actual %0b",
                                 $time, want.balanced, out_ch.balanced);
                        n_fail++;
                    end
                    if (out_ch.status !== want.status) begin
                        $display("%0t: status expected %0d actual %0d",
                                 $time, want.status, out_ch.status);
                        n_fail++;
                    end
                end
            end
            out_ch.ready <= quiet || ($urandom_range(0, 99) >= 10);
        end
    end

    initial begin
        #2_000_000;
        $display("Test completed with failures");
        $finish;
    end

    initial begin
        int r;
        in_ch.valid  = 1'b0;
        in_ch.ch     = 8'h00;
        in_ch.last   = 1'b0;
        out_ch.ready = 1'b0;
        i_rst_n      = 1'b0;

        // directed strings
        push_text("([{}])");          // every opener and closer, balanced
        push_text("]");               // closer with nothing open
        push_text("(}");              // wrong closer kind
        push_text("[");               // left open at the end
        push_text("(]({");            // failure stays, later opens ignored
        push_text("}[");              // empty-stack failure beats unclosed
        push_text("{)");              // mismatch on the last word itself
        push_char(8'h00, 1'b0);       // NUL and all-ones are plain bytes
        push_char(8'hFF, 1'b0);
        push_char(CH_OPEN_SQUARE, 1'b0);
        push_char(8'h00, 1'b0);
        push_char(CH_CLOSE_SQUARE, 1'b1);
        push_text("A");               // no brackets at all

        // full stack exactly, then two pushes too many
        hold_next = 1'b1;
        gen_deep(BBC_STACK_DEPTH, 1'b1);
        hold_next = 1'b1;
        gen_deep(BBC_STACK_DEPTH + 2, 1'b0);

        while (n_live < 1600) begin
            hold_next = ($urandom_range(0, 99) < 3);
            r = $urandom_range(0, 99);
            if (r < 70)
                gen_nested(24, $urandom_range(0, 99) < 30);
            else if (r < 85)
                gen_noise(12);
            else
                gen_nested(160, $urandom_range(0, 99) < 30);
        end

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (text_q.size() != 0 || in_ch.valid || verdict_q.size() != 0)
            @(posedge i_clk);
        repeat (10) @(posedge i_clk);

        if (n_fail == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

[sim.f]
hdl/bbc_pkg.sv
hdl/bbc_if.sv
hdl/bbc_stack_mem.sv
hdl/bbc_out_reg.sv
hdl/bracket_balance_checker.sv
hdl/bbc_checker.sv
dv/bracket_balance_checker_tb.sv
